### design/pmc_pkg.sv
// Shared types and constants for the PS/2 mouse packet cursor unit.
// Used by the front, the packet queue, the back and the top level.
package pmc_pkg;

	localparam int SCREEN_COLUMNS = 80;
	localparam int SCREEN_ROWS = 25;

	localparam int COL_W = 7;
	localparam int ROW_W = 5;
	localparam int TAB_W = 3;
	localparam int RES_W = 2 * COL_W + 2 * ROW_W + 1 + TAB_W;
	localparam int TDATA_OUT_W = ((RES_W + 7) / 8) * 8;

	localparam logic [TAB_W-1:0] TAB_NONE = 3'd0;
	localparam logic [TAB_W-1:0] TAB_ONE = 3'd1;
	localparam logic [TAB_W-1:0] TAB_TWO = 3'd2;
	localparam logic [TAB_W-1:0] TAB_THREE = 3'd3;
	localparam logic [TAB_W-1:0] TAB_FOUR = 3'd4;

	typedef struct packed {
		logic [7:0] y_byte;
		logic [7:0] x_byte;
		logic [7:0] status;
	} packet_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic [TAB_W-1:0] tab_hit;
		logic left_pressed;
		logic [ROW_W-1:0] old_y;
		logic [COL_W-1:0] old_x;
		logic [ROW_W-1:0] cursor_y;
		logic [COL_W-1:0] cursor_x;
	} result_t;

endpackage

### design/ps2_mouse_packet_cursor_unit.sv
// A result reaches m_tvalid through two registers: the packet queue entry, then the output register.
// Throughput: one byte per cycle; the front stalls only on a third byte while
// the two-entry packet queue is full, which the output register's stall sets.
// Reset (arst_n low, asynchronous): byte phase to status byte, queue and output
// emptied, cursor to column 0, row 0.
// Top level: front, packet queue and back; depends on pmc_pkg.
module ps2_mouse_packet_cursor_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,  // data_byte[7:0]
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// cursor_x[6:0], cursor_y[11:7], old_x[18:12], old_y[23:19],
	// left_pressed[24], tab_hit[27:25], zero[31:28]
	output logic [pmc_pkg::TDATA_OUT_W-1:0]     m_tdata
);

	pmc_pkg::q_stat_t q_stat;
	pmc_pkg::packet_t push_pkt;
	pmc_pkg::packet_t head;
	pmc_pkg::result_t res;
	logic             push;
	logic             pop;

	pmc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_stat   (q_stat),
		.push     (push),
		.push_pkt (push_pkt)
	);

	pmc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_pkt (push_pkt),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	pmc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.res      (res)
	);

	assign m_tdata = {{(pmc_pkg::TDATA_OUT_W - pmc_pkg::RES_W){1'b0}}, res};

endmodule

### design/pmc_front.sv
// Front part: accepts mouse bytes and groups them into three-byte packets.
// Depends on pmc_pkg; pushes complete packets into the packet queue.
module pmc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // data_byte[7:0]
	input  pmc_pkg::q_stat_t  q_stat,
	output logic              push,
	output pmc_pkg::packet_t  push_pkt
);

	typedef enum logic [2:0] {
		PH_STATUS = 3'b001,
		PH_XDELTA = 3'b010,
		PH_YDELTA = 3'b100
	} phase_t;

	phase_t     phase_q;
	logic [7:0] status_q;
	logic [7:0] x_byte_q;
	logic       accept;

	assign s_tready = (phase_q != PH_YDELTA) || !q_stat.full;
	assign accept = s_tvalid && s_tready;
	assign push = accept && (phase_q == PH_YDELTA);
	assign push_pkt = '{y_byte: s_tdata, x_byte: x_byte_q, status: status_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_STATUS;
		end else if (accept) begin
			unique case (phase_q)
				PH_XDELTA: phase_q <= PH_YDELTA;
				PH_YDELTA: phase_q <= PH_STATUS;
				default:   phase_q <= PH_XDELTA;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && phase_q == PH_XDELTA) begin
			x_byte_q <= s_tdata;
		end
		if (accept && phase_q != PH_XDELTA && phase_q != PH_YDELTA) begin
			status_q <= s_tdata;
		end
	end

endmodule

### design/pmc_queue.sv
// Two-entry packet queue between the front and the back.
// Depends on pmc_pkg for the packet and status types.
module pmc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pmc_pkg::packet_t  push_pkt,
	input  logic              pop,
	output pmc_pkg::packet_t  head,
	output pmc_pkg::q_stat_t  q_stat
);

	pmc_pkg::packet_t entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign head = entry_q[rd_ptr_q];
	assign q_stat = '{full: count_q == 2'd2, empty: count_q == 2'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			priority if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end else begin
				count_q <= count_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_pkt;
		end
	end

`ifndef ASSERT_OFF
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty) else $error("pop from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");
`endif

endmodule

### design/pmc_back.sv
// Back part: applies a packet to the cursor and registers the result.
// Depends on pmc_pkg; pops packets from the packet queue.
module pmc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  pmc_pkg::packet_t  head,
	input  pmc_pkg::q_stat_t  q_stat,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output pmc_pkg::result_t  res
);

	localparam logic signed [9:0] XMax = 10'(pmc_pkg::SCREEN_COLUMNS - 1);
	localparam logic signed [9:0] YMax = 10'(pmc_pkg::SCREEN_ROWS - 1);

	logic [pmc_pkg::COL_W-1:0] pos_x_q;
	logic [pmc_pkg::ROW_W-1:0] pos_y_q;
	logic                      valid_q;
	pmc_pkg::result_t          res_q;

	logic signed [9:0]         dx;
	logic signed [9:0]         dy;
	logic signed [9:0]         sum_x;
	logic signed [9:0]         sum_y;
	logic [pmc_pkg::COL_W-1:0] new_x;
	logic [pmc_pkg::ROW_W-1:0] new_y;
	logic                      left;
	logic [pmc_pkg::TAB_W-1:0] tab;

	assign pop = !q_stat.empty && (!valid_q || m_tready);
	assign m_tvalid = valid_q;
	assign res = res_q;
	assign left = head.status[0];

	always_comb begin
		dx = $signed({head.status[4], head.status[4], head.x_byte});
		dy = $signed({head.status[5], head.status[5], head.y_byte});
		sum_x = $signed({3'b000, pos_x_q}) + dx;
		sum_y = $signed({5'b00000, pos_y_q}) - dy;
		priority if (sum_x < 10'sd0) begin
			new_x = '0;
		end else if (sum_x > XMax) begin
			new_x = XMax[pmc_pkg::COL_W-1:0];
		end else begin
			new_x = sum_x[pmc_pkg::COL_W-1:0];
		end
		priority if (sum_y < 10'sd0) begin
			new_y = '0;
		end else if (sum_y > YMax) begin
			new_y = YMax[pmc_pkg::ROW_W-1:0];
		end else begin
			new_y = sum_y[pmc_pkg::ROW_W-1:0];
		end
		priority if (!left || pos_y_q != '0) begin
			tab = pmc_pkg::TAB_NONE;
		end else if (pos_x_q < 7'd8) begin
			tab = pmc_pkg::TAB_ONE;
		end else if (pos_x_q > 7'd10 && pos_x_q < 7'd19) begin
			tab = pmc_pkg::TAB_TWO;
		end else if (pos_x_q > 7'd21 && pos_x_q < 7'd30) begin
			tab = pmc_pkg::TAB_THREE;
		end else if (pos_x_q > 7'd32 && pos_x_q < 7'd41) begin
			tab = pmc_pkg::TAB_FOUR;
		end else begin
			tab = pmc_pkg::TAB_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				pos_x_q <= new_x;
				pos_y_q <= new_y;
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= '{tab_hit: tab, left_pressed: left, old_y: pos_y_q, old_x: pos_x_q,
				cursor_y: new_y, cursor_x: new_x};
		end
	end

`ifndef ASSERT_OFF
	a_x_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		pos_x_q <= XMax[pmc_pkg::COL_W-1:0]) else $error("cursor column off screen");
	a_y_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		pos_y_q <= YMax[pmc_pkg::ROW_W-1:0]) else $error("cursor row off screen");
	a_tab_needs_press: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && res_q.tab_hit != pmc_pkg::TAB_NONE) |->
			(res_q.left_pressed && res_q.old_y == '0))
		else $error("tab hit without left press on top row");
	a_pos_tracks_result: assert property (@(posedge clk) disable iff (!arst_n)
		$past(pop) |-> (res_q.cursor_x == pos_x_q && res_q.cursor_y == pos_y_q))
		else $error("result does not match cursor state");
`endif

endmodule

### tb/tb.sv
// Self-checking bench for ps2_mouse_packet_cursor_unit: a cursor tracker class mirrors the
// packet grouping, delta extension, saturation and tab decode, and checks every result.
// Depends on pmc_pkg and the top level; drives the byte stream and result stream with idling.
module tb;

	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int BYTES_PER_PHASE = 500;
	localparam int DRAIN_CYCLES = 10;

	class cursor_tracker;
		logic [1:0] phase;
		logic [7:0] status;
		logic [7:0] x_byte;
		logic [pmc_pkg::COL_W-1:0] col;
		logic [pmc_pkg::ROW_W-1:0] row;
		pmc_pkg::result_t pending_moves[$];
		int errors;

		function new();
			phase = 2'd0;
			status = 8'd0;
			x_byte = 8'd0;
			col = '0;
			row = '0;
			errors = 0;
		endfunction

		function logic [pmc_pkg::TAB_W-1:0] tab_at(logic [pmc_pkg::COL_W-1:0] c,
			logic [pmc_pkg::ROW_W-1:0] r);
			if (r != 0)
				return pmc_pkg::TAB_NONE;
			if (c < 8)
				return pmc_pkg::TAB_ONE;
			if (c > 10 && c < 19)
				return pmc_pkg::TAB_TWO;
			if (c > 21 && c < 30)
				return pmc_pkg::TAB_THREE;
			if (c > 32 && c < 41)
				return pmc_pkg::TAB_FOUR;
			return pmc_pkg::TAB_NONE;
		endfunction

		function void take_byte(logic [7:0] b);
			int dx;
			int dy;
			int nx;
			int ny;
			pmc_pkg::result_t mv;
			case (phase)
				2'd1: begin
					x_byte = b;
					phase = 2'd2;
				end
				2'd2: begin
					phase = 2'd0;
					dx = int'(x_byte) - (status[4] ? 256 : 0);
					dy = int'(b) - (status[5] ? 256 : 0);
					nx = int'(col) + dx;
					ny = int'(row) - dy;
					if (nx < 0)
						nx = 0;
					if (nx > pmc_pkg::SCREEN_COLUMNS - 1)
						nx = pmc_pkg::SCREEN_COLUMNS - 1;
					if (ny < 0)
						ny = 0;
					if (ny > pmc_pkg::SCREEN_ROWS - 1)
						ny = pmc_pkg::SCREEN_ROWS - 1;
					mv.old_x = col;
					mv.old_y = row;
					mv.left_pressed = status[0];
					mv.tab_hit = status[0] ? tab_at(col, row) : pmc_pkg::TAB_NONE;
					col = pmc_pkg::COL_W'(nx);
					row = pmc_pkg::ROW_W'(ny);
					mv.cursor_x = col;
					mv.cursor_y = row;
					pending_moves.push_back(mv);
				end
				default: begin
					status = b;
					phase = 2'd1;
				end
			endcase
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_move(logic [pmc_pkg::TDATA_OUT_W-1:0] d);
			pmc_pkg::result_t want;
			pmc_pkg::result_t got;
			if (pending_moves.size() == 0) begin
				report($sformatf("unexpected result %h", d));
				return;
			end
			want = pending_moves.pop_front();
			got = pmc_pkg::result_t'(d[pmc_pkg::RES_W-1:0]);
			if (got.cursor_x != want.cursor_x)
				report($sformatf("cursor_x %0d, want %0d", got.cursor_x, want.cursor_x));
			if (got.cursor_y != want.cursor_y)
				report($sformatf("cursor_y %0d, want %0d", got.cursor_y, want.cursor_y));
			if (got.old_x != want.old_x)
				report($sformatf("old_x %0d, want %0d", got.old_x, want.old_x));
			if (got.old_y != want.old_y)
				report($sformatf("old_y %0d, want %0d", got.old_y, want.old_y));
			if (got.left_pressed != want.left_pressed)
				report($sformatf("left_pressed %0b, want %0b", got.left_pressed,
					want.left_pressed));
			if (got.tab_hit != want.tab_hit)
				report($sformatf("tab_hit %0d, want %0d", got.tab_hit, want.tab_hit));
			if (d[pmc_pkg::TDATA_OUT_W-1:pmc_pkg::RES_W] != 0)
				report($sformatf("padding bits set in %h", d));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'd0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [pmc_pkg::TDATA_OUT_W-1:0] m_tdata;

	cursor_tracker tracker = new();
	int src_idle = 0;
	int snk_stall = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int quiet = 0;

	ps2_mouse_packet_cursor_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_stall);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_move(m_tdata);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("ps2_mouse_packet_cursor_unit verification failed");
			$finish;
		end
	end

	task send_byte(logic [7:0] b);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do
			@(posedge clk);
		while (!s_tready);
		tracker.take_byte(b);
		@(negedge clk);
	endtask

	function logic [7:0] pick_delta(int mode, bit neg);
		if (mode == 1)
			return neg ? 8'(256 - $urandom_range(1, 12)) : 8'($urandom_range(0, 12));
		return 8'($urandom_range(255));
	endfunction

	task send_random_packet();
		logic [7:0] st;
		logic [7:0] dx;
		logic [7:0] dy;
		int mode;
		st = 8'($urandom_range(255));
		mode = $urandom_range(2);
		dx = pick_delta(mode, st[4]);
		if (mode == 2) begin
			st[5] = 1'b0;
			dy = 8'($urandom_range(24, 255));
		end else begin
			dy = pick_delta(mode, st[5]);
		end
		send_byte(st);
		send_byte(dx);
		send_byte(dy);
	endtask

	task drain();
		while (tracker.pending_moves.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	logic [7:0] directed_bytes [24] = '{
		8'h01, 8'h00, 8'h00,
		8'h01, 8'h0F, 8'h00,
		8'h01, 8'h0A, 8'h00,
		8'h01, 8'h0A, 8'h00,
		8'h01, 8'h06, 8'h00,
		8'hF1, 8'h00, 8'h00,
		8'h21, 8'hFF, 8'hFF,
		8'h10, 8'h01, 8'h7F
	};

	int src_pct [4] = '{0, 83, 0, 36};
	int snk_pct [4] = '{0, 0, 83, 36};

	initial begin
		int sent;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (directed_bytes[i])
			send_byte(directed_bytes[i]);
		s_tvalid <= 1'b0;
		drain();
		for (int p = 0; p < 4; p++) begin
			src_idle = src_pct[p];
			snk_stall = snk_pct[p];
			sent = 0;
			while (sent < BYTES_PER_PHASE) begin
				if (p == 0 && sent >= 100 && sent < 103)
					hold_req = 1'b1;
				if ($urandom_range(9) == 0) begin
					send_byte(8'($urandom_range(255)));
					sent += 1;
				end else begin
					send_random_packet();
					sent += 3;
				end
			end
			s_tvalid <= 1'b0;
			drain();
		end
		src_idle = 0;
		snk_stall = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0)
			$display("ps2_mouse_packet_cursor_unit verification clean");
		else
			$display("ps2_mouse_packet_cursor_unit verification failed");
		$finish;
	end
endmodule

### filelist.f
design/pmc_pkg.sv
design/pmc_front.sv
design/pmc_queue.sv
design/pmc_back.sv
design/ps2_mouse_packet_cursor_unit.sv
tb/tb.sv
